### hw/rtl/rbx_pkg.sv
// ----------------------------------------------------------------------------
// rbx_pkg
// Shared types and constants of the register bytecode execution unit:
// payload structs, opcodes, error codes and the decoded command.
// ----------------------------------------------------------------------------
package rbx_pkg;

    // Input modes
    localparam logic [1:0] MODE_WSLOT  = 2'd0;
    localparam logic [1:0] MODE_WCONST = 2'd1;
    localparam logic [1:0] MODE_EXEC   = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    // Opcodes
    localparam logic [7:0] OP_ISEQN = 8'd0;
    localparam logic [7:0] OP_ISNEN = 8'd1;
    localparam logic [7:0] OP_JMP   = 8'd2;
    localparam logic [7:0] OP_MOV   = 8'd3;
    localparam logic [7:0] OP_NOT   = 8'd4;
    localparam logic [7:0] OP_UNM   = 8'd5;
    localparam logic [7:0] OP_ABS   = 8'd6;
    localparam logic [7:0] OP_ADDVN = 8'd7;
    localparam logic [7:0] OP_SUBVN = 8'd8;
    localparam logic [7:0] OP_MULVN = 8'd9;
    localparam logic [7:0] OP_DIVVN = 8'd10;
    localparam logic [7:0] OP_MODVN = 8'd11;
    localparam logic [7:0] OP_ADDNV = 8'd12;
    localparam logic [7:0] OP_SUBNV = 8'd13;
    localparam logic [7:0] OP_MULNV = 8'd14;
    localparam logic [7:0] OP_DIVNV = 8'd15;
    localparam logic [7:0] OP_MODNV = 8'd16;
    localparam logic [7:0] OP_ADDVV = 8'd17;
    localparam logic [7:0] OP_SUBVV = 8'd18;
    localparam logic [7:0] OP_MULVV = 8'd19;
    localparam logic [7:0] OP_DIVVV = 8'd20;
    localparam logic [7:0] OP_MODVV = 8'd21;
    localparam logic [7:0] OP_KNUM  = 8'd22;
    localparam logic [7:0] OP_KLIT  = 8'd23;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        instruction;
        logic [7:0]         index;
        logic signed [63:0] value;
    } t_in;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               done_res;
        logic signed [63:0] read_value;
        logic [1:0]         error;
    } t_out;

    // Command classes after decode
    typedef enum logic [3:0] {
        CLS_WSLOT, CLS_WCONST, CLS_READ, CLS_SKIPEQ, CLS_SKIPNE, CLS_JMP,
        CLS_MOV, CLS_NOT, CLS_UNM, CLS_ABS, CLS_ARITH, CLS_KNUM, CLS_KLIT, CLS_NOP
    } t_cls;

    typedef enum logic [2:0] {
        KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD
    } t_kind;

    // Operand arrangement: slot/literal, literal/slot, slot/slot
    typedef enum logic [1:0] {
        GRP_SL, GRP_LS, GRP_SS
    } t_grp;

    typedef struct packed {
        t_cls               cls;
        t_kind              kind;
        t_grp               grp;
        logic               rng_err;
        logic [7:0]         dst;
        logic [7:0]         rd0;
        logic [7:0]         rd1;
        logic [15:0]        caddr;
        logic [15:0]        d;
        logic [7:0]         c;
        logic [63:0]        value;
    } t_cmd;

    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

### hw/rtl/rbx_front.sv
// ----------------------------------------------------------------------------
// rbx_front
// Accepts input transactions, decodes the mode and the bytecode word, checks
// all index ranges and pushes one command into the queue.
// ----------------------------------------------------------------------------
module rbx_front #(
    parameter int unsigned NUM_SLOTS     = 256,
    parameter int unsigned NUM_CONSTANTS = 256
) (
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rbx_pkg::t_in  i_in_data,
    input  logic          i_full,
    output logic          o_push,
    output rbx_pkg::t_cmd o_cmd
);

    logic [7:0]  op;
    logic [7:0]  fa;
    logic [7:0]  fb;
    logic [7:0]  fc;
    logic [15:0] fd;
    logic        a_ok;
    logic        b_ok;
    logic        c_ok;
    logic        d_ok;
    logic        dk_ok;
    logic        idx_ok;
    logic        idxk_ok;

    // Split the word into its fields
    assign op = i_in_data.instruction[7:0];
    assign fa = i_in_data.instruction[15:8];
    assign fc = i_in_data.instruction[23:16];
    assign fb = i_in_data.instruction[31:24];
    assign fd = i_in_data.instruction[31:16];

    // Range checks against the store depths
    assign a_ok    = {1'b0, fa} < 9'(NUM_SLOTS);
    assign b_ok    = {1'b0, fb} < 9'(NUM_SLOTS);
    assign c_ok    = {1'b0, fc} < 9'(NUM_SLOTS);
    assign d_ok    = {1'b0, fd} < 17'(NUM_SLOTS);
    assign dk_ok   = {1'b0, fd} < 17'(NUM_CONSTANTS);
    assign idx_ok  = {1'b0, i_in_data.index} < 9'(NUM_SLOTS);
    assign idxk_ok = {9'b0, i_in_data.index} < 17'(NUM_CONSTANTS);

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    // Decode into a command
    always_comb begin
        o_cmd         = '0;
        o_cmd.cls     = rbx_pkg::CLS_NOP;
        o_cmd.kind    = rbx_pkg::KIND_ADD;
        o_cmd.grp     = rbx_pkg::GRP_SL;
        o_cmd.d       = fd;
        o_cmd.c       = fc;
        o_cmd.value   = i_in_data.value;
        unique case (i_in_data.mode)
            rbx_pkg::MODE_WSLOT: begin
                o_cmd.cls     = rbx_pkg::CLS_WSLOT;
                o_cmd.dst     = i_in_data.index;
                o_cmd.rng_err = !idx_ok;
            end
            rbx_pkg::MODE_WCONST: begin
                o_cmd.cls     = rbx_pkg::CLS_WCONST;
                o_cmd.caddr   = {8'b0, i_in_data.index};
                o_cmd.rng_err = !idxk_ok;
            end
            rbx_pkg::MODE_READ: begin
                o_cmd.cls     = rbx_pkg::CLS_READ;
                o_cmd.rd0     = i_in_data.index;
                o_cmd.rng_err = !idx_ok;
            end
            default: begin
                o_cmd.dst = fa;
                unique case (op)
                    rbx_pkg::OP_ISEQN, rbx_pkg::OP_ISNEN: begin
                        o_cmd.cls     = (op == rbx_pkg::OP_ISEQN) ? rbx_pkg::CLS_SKIPEQ
                                                                  : rbx_pkg::CLS_SKIPNE;
                        o_cmd.rd0     = fa;
                        o_cmd.rng_err = !a_ok;
                    end
                    rbx_pkg::OP_JMP: begin
                        o_cmd.cls = rbx_pkg::CLS_JMP;
                    end
                    rbx_pkg::OP_MOV, rbx_pkg::OP_NOT, rbx_pkg::OP_UNM, rbx_pkg::OP_ABS: begin
                        unique case (op)
                            rbx_pkg::OP_MOV: o_cmd.cls = rbx_pkg::CLS_MOV;
                            rbx_pkg::OP_NOT: o_cmd.cls = rbx_pkg::CLS_NOT;
                            rbx_pkg::OP_UNM: o_cmd.cls = rbx_pkg::CLS_UNM;
                            default:         o_cmd.cls = rbx_pkg::CLS_ABS;
                        endcase
                        o_cmd.rd0     = fd[7:0];
                        o_cmd.rng_err = !a_ok || !d_ok;
                    end
                    rbx_pkg::OP_ADDVN, rbx_pkg::OP_SUBVN, rbx_pkg::OP_MULVN,
                    rbx_pkg::OP_DIVVN, rbx_pkg::OP_MODVN,
                    rbx_pkg::OP_ADDNV, rbx_pkg::OP_SUBNV, rbx_pkg::OP_MULNV,
                    rbx_pkg::OP_DIVNV, rbx_pkg::OP_MODNV,
                    rbx_pkg::OP_ADDVV, rbx_pkg::OP_SUBVV, rbx_pkg::OP_MULVV,
                    rbx_pkg::OP_DIVVV, rbx_pkg::OP_MODVV: begin
                        o_cmd.cls = rbx_pkg::CLS_ARITH;
                        o_cmd.rd0 = fb;
                        o_cmd.rd1 = fc;
                        unique case (op)
                            rbx_pkg::OP_ADDVN, rbx_pkg::OP_ADDNV, rbx_pkg::OP_ADDVV:
                                o_cmd.kind = rbx_pkg::KIND_ADD;
                            rbx_pkg::OP_SUBVN, rbx_pkg::OP_SUBNV, rbx_pkg::OP_SUBVV:
                                o_cmd.kind = rbx_pkg::KIND_SUB;
                            rbx_pkg::OP_MULVN, rbx_pkg::OP_MULNV, rbx_pkg::OP_MULVV:
                                o_cmd.kind = rbx_pkg::KIND_MUL;
                            rbx_pkg::OP_DIVVN, rbx_pkg::OP_DIVNV, rbx_pkg::OP_DIVVV:
                                o_cmd.kind = rbx_pkg::KIND_DIV;
                            default:
                                o_cmd.kind = rbx_pkg::KIND_MOD;
                        endcase
                        priority if (op <= rbx_pkg::OP_MODVN) begin
                            o_cmd.grp = rbx_pkg::GRP_SL;
                        end else if (op <= rbx_pkg::OP_MODNV) begin
                            o_cmd.grp = rbx_pkg::GRP_LS;
                        end else begin
                            o_cmd.grp = rbx_pkg::GRP_SS;
                        end
                        o_cmd.rng_err = !a_ok || !b_ok
                                        || ((op >= rbx_pkg::OP_ADDVV) && !c_ok);
                    end
                    rbx_pkg::OP_KNUM: begin
                        o_cmd.cls     = rbx_pkg::CLS_KNUM;
                        o_cmd.caddr   = fd;
                        o_cmd.rng_err = !a_ok || !dk_ok;
                    end
                    rbx_pkg::OP_KLIT: begin
                        o_cmd.cls     = rbx_pkg::CLS_KLIT;
                        o_cmd.rng_err = !a_ok;
                    end
                    default: begin
                        o_cmd.cls = rbx_pkg::CLS_NOP;
                    end
                endcase
            end
        endcase
    end

endmodule

### hw/rtl/rbx_queue.sv
// ----------------------------------------------------------------------------
// rbx_queue
// Short command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module rbx_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rbx_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rbx_pkg::t_cmd o_cmd
);

    localparam int unsigned PW = $clog2(rbx_pkg::QUEUE_DEPTH);

    rbx_pkg::t_cmd r_mem [rbx_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic [PW:0]   n_cnt;

    assign o_full  = r_cnt == (PW+1)'(rbx_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];

    // Advance pointers and count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp  = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp  = r_rp + 1'b1;
        end
        n_cnt = r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

### hw/rtl/rbx_back.sv
// ----------------------------------------------------------------------------
// rbx_back
// Execution sequencer: slot file and constant memory, program counter,
// shared 32x32 multiplier, bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module rbx_back #(
    parameter int unsigned NUM_SLOTS     = 256,
    parameter int unsigned NUM_CONSTANTS = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_prog_len,
    input  logic           i_cmd_valid,
    input  rbx_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rbx_pkg::t_out  o_out_data
);

    localparam int unsigned SAW = $clog2(NUM_SLOTS);
    localparam int unsigned CAW = (NUM_CONSTANTS > 1) ? $clog2(NUM_CONSTANTS) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_OPER = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_DFIX = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // Memories and valid bits
    logic [63:0]          r_slot_mem  [NUM_SLOTS];
    logic [63:0]          r_const_mem [NUM_CONSTANTS];
    logic [NUM_SLOTS-1:0] r_slot_vld;
    logic [63:0]          r_rd0_q;
    logic [63:0]          r_rd1_q;
    logic                 r_rd0_v;
    logic                 r_rd1_v;
    logic [63:0]          r_kq;

    // Sequencer state
    t_state        r_state, n_state;
    rbx_pkg::t_cmd r_cmd, n_cmd;
    logic [15:0]   r_pc, n_pc;
    logic [15:0]   r_npc, n_npc;
    logic [63:0]   r_res, n_res;
    logic [1:0]    r_err, n_err;
    logic          r_wr, n_wr;
    logic          r_cwr, n_cwr;
    logic [63:0]   r_rdv, n_rdv;
    logic [63:0]   r_x, n_x;
    logic [63:0]   r_y, n_y;
    logic [63:0]   r_q, n_q;
    logic [63:0]   r_rem, n_rem;
    logic          r_negq, n_negq;
    logic          r_negr, n_negr;
    logic [5:0]    r_step, n_step;
    logic          r_ovld, n_ovld;
    rbx_pkg::t_out r_out, n_out;

    logic          slot_we;
    logic          const_we;
    logic [63:0]   s0;
    logic [63:0]   s1;
    logic [63:0]   lit8;
    logic [63:0]   lit16;
    logic [63:0]   opx;
    logic [63:0]   opy;
    logic [31:0]   ma;
    logic [31:0]   mb;
    logic [63:0]   prod;
    logic [64:0]   dtry;
    logic [64:0]   ddiff;
    logic [17:0]   jt;
    logic [16:0]   nxt;
    logic          run;
    logic          is_exec;
    logic          skip;
    logic          jmpv;

    assign s0    = r_rd0_v ? r_rd0_q : 64'd0;
    assign s1    = r_rd1_v ? r_rd1_q : 64'd0;
    assign lit8  = {{56{r_cmd.c[7]}}, r_cmd.c};
    assign lit16 = {{48{r_cmd.d[15]}}, r_cmd.d};
    assign run   = r_pc < i_prog_len;
    assign jt    = {2'b0, r_pc} + 18'd1 + {{2{r_cmd.d[15]}}, r_cmd.d};

    // Arithmetic operands by group
    always_comb begin
        unique case (r_cmd.grp)
            rbx_pkg::GRP_SL: begin opx = s0;   opy = lit8; end
            rbx_pkg::GRP_LS: begin opx = lit8; opy = s0;   end
            default:         begin opx = s0;   opy = s1;   end
        endcase
    end

    // Shared multiplier: one 32x32 partial product per step
    always_comb begin
        unique case (r_step[1:0])
            2'd0:    begin ma = r_x[31:0];  mb = r_y[31:0];  end
            2'd1:    begin ma = r_x[31:0];  mb = r_y[63:32]; end
            default: begin ma = r_x[63:32]; mb = r_y[31:0];  end
        endcase
    end
    assign prod = {32'b0, ma} * {32'b0, mb};

    // Divider trial subtraction
    assign dtry  = {r_rem, r_q[63]};
    assign ddiff = dtry - {1'b0, r_y};

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_pc     = r_pc;
        n_npc    = r_npc;
        n_res    = r_res;
        n_err    = r_err;
        n_wr     = r_wr;
        n_cwr    = r_cwr;
        n_rdv    = r_rdv;
        n_x      = r_x;
        n_y      = r_y;
        n_q      = r_q;
        n_rem    = r_rem;
        n_negq   = r_negq;
        n_negr   = r_negr;
        n_step   = r_step;
        n_out    = r_out;
        n_ovld   = r_ovld && !i_out_ready;
        o_pop    = 1'b0;
        slot_we  = 1'b0;
        const_we = 1'b0;
        is_exec  = 1'b0;
        skip     = 1'b0;
        jmpv     = 1'b0;
        nxt      = '0;
        unique case (r_state)
            S_IDLE: begin
                // Take the next command and issue its reads
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = S_OPER;
                end
            end
            S_OPER: begin
                n_err   = rbx_pkg::ERR_NONE;
                n_wr    = 1'b0;
                n_cwr   = 1'b0;
                n_rdv   = '0;
                n_npc   = r_pc;
                n_state = S_FIN;
                unique case (r_cmd.cls)
                    rbx_pkg::CLS_WSLOT: begin
                        if (r_cmd.rng_err) begin
                            n_err = rbx_pkg::ERR_RANGE;
                        end else begin
                            n_wr  = 1'b1;
                            n_res = r_cmd.value;
                        end
                    end
                    rbx_pkg::CLS_WCONST: begin
                        if (r_cmd.rng_err) begin
                            n_err = rbx_pkg::ERR_RANGE;
                        end else begin
                            n_cwr = 1'b1;
                            n_res = r_cmd.value;
                        end
                    end
                    rbx_pkg::CLS_READ: begin
                        if (r_cmd.rng_err) begin
                            n_err = rbx_pkg::ERR_RANGE;
                        end else begin
                            n_rdv = s0;
                        end
                    end
                    rbx_pkg::CLS_SKIPEQ, rbx_pkg::CLS_SKIPNE: begin
                        is_exec = 1'b1;
                        if (run && r_cmd.rng_err) begin
                            n_err = rbx_pkg::ERR_RANGE;
                        end
                        skip = (s0 == lit16) ^ (r_cmd.cls == rbx_pkg::CLS_SKIPNE);
                    end
                    rbx_pkg::CLS_JMP: begin
                        is_exec = 1'b1;
                        jmpv    = 1'b1;
                        if (run && (jt[17] || (jt[16:0] > {1'b0, i_prog_len}))) begin
                            n_err = rbx_pkg::ERR_RANGE;
                        end
                    end
                    rbx_pkg::CLS_MOV, rbx_pkg::CLS_NOT, rbx_pkg::CLS_UNM,
                    rbx_pkg::CLS_ABS, rbx_pkg::CLS_KNUM, rbx_pkg::CLS_KLIT: begin
                        is_exec = 1'b1;
                        if (run) begin
                            if (r_cmd.rng_err) begin
                                n_err = rbx_pkg::ERR_RANGE;
                            end else begin
                                n_wr = 1'b1;
                            end
                        end
                        unique case (r_cmd.cls)
                            rbx_pkg::CLS_MOV:  n_res = s0;
                            rbx_pkg::CLS_NOT:  n_res = (s0 == 64'd0) ? 64'd1 : 64'd0;
                            rbx_pkg::CLS_UNM:  n_res = 64'd0 - s0;
                            rbx_pkg::CLS_ABS:  n_res = s0[63] ? 64'd0 - s0 : s0;
                            rbx_pkg::CLS_KNUM: n_res = r_kq;
                            default:           n_res = lit16;
                        endcase
                    end
                    rbx_pkg::CLS_ARITH: begin
                        is_exec = 1'b1;
                        if (run) begin
                            priority if (r_cmd.rng_err) begin
                                n_err = rbx_pkg::ERR_RANGE;
                            end else if (((r_cmd.kind == rbx_pkg::KIND_DIV)
                                          || (r_cmd.kind == rbx_pkg::KIND_MOD))
                                         && (opy == 64'd0)) begin
                                n_err = rbx_pkg::ERR_DIV0;
                            end else begin
                                n_wr = 1'b1;
                                unique case (r_cmd.kind)
                                    rbx_pkg::KIND_ADD: n_res = opx + opy;
                                    rbx_pkg::KIND_SUB: n_res = opx - opy;
                                    rbx_pkg::KIND_MUL: begin
                                        n_x     = opx;
                                        n_y     = opy;
                                        n_step  = '0;
                                        n_state = S_MUL;
                                    end
                                    default: begin
                                        n_q     = opx[63] ? 64'd0 - opx : opx;
                                        n_y     = opy[63] ? 64'd0 - opy : opy;
                                        n_rem   = '0;
                                        n_negq  = opx[63] ^ opy[63];
                                        n_negr  = opx[63];
                                        n_step  = '0;
                                        n_state = S_DIV;
                                    end
                                endcase
                            end
                        end
                    end
                    default: begin
                        is_exec = 1'b1;
                    end
                endcase
                // Next program counter, clamped to the program length
                if (is_exec && run) begin
                    nxt = {1'b0, r_pc} + 17'd1;
                    if (n_err == rbx_pkg::ERR_NONE) begin
                        if (skip) begin
                            nxt = {1'b0, r_pc} + 17'd2;
                        end
                        if (jmpv) begin
                            nxt = jt[16:0];
                        end
                    end
                    if (nxt > {1'b0, i_prog_len}) begin
                        nxt = {1'b0, i_prog_len};
                    end
                    n_npc = nxt[15:0];
                end
            end
            S_MUL: begin
                // Accumulate partial products
                if (r_step[1:0] == 2'd0) begin
                    n_res = prod;
                end else begin
                    n_res = r_res + {prod[31:0], 32'b0};
                end
                n_step = r_step + 6'd1;
                if (r_step[1:0] == 2'd2) begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                // One quotient bit per cycle
                if (!ddiff[64]) begin
                    n_rem = ddiff[63:0];
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = dtry[63:0];
                    n_q   = {r_q[62:0], 1'b0};
                end
                n_step = r_step + 6'd1;
                if (r_step == 6'd63) begin
                    n_state = S_DFIX;
                end
            end
            S_DFIX: begin
                // Apply signs: quotient toward zero, remainder follows dividend
                if (r_cmd.kind == rbx_pkg::KIND_MOD) begin
                    n_res = r_negr ? 64'd0 - r_rem : r_rem;
                end else begin
                    n_res = r_negq ? 64'd0 - r_q : r_q;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                // Commit once the output register is free
                if (!r_ovld || i_out_ready) begin
                    slot_we          = r_wr;
                    const_we         = r_cwr;
                    n_pc             = r_npc;
                    n_ovld           = 1'b1;
                    n_out.next_pc    = r_npc;
                    n_out.done_res   = r_npc >= i_prog_len;
                    n_out.read_value = r_rdv;
                    n_out.error      = r_err;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pc       <= '0;
            r_ovld     <= 1'b0;
            r_slot_vld <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_ovld  <= n_ovld;
            if (slot_we) begin
                r_slot_vld[r_cmd.dst[SAW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_npc  <= n_npc;
        r_res  <= n_res;
        r_err  <= n_err;
        r_wr   <= n_wr;
        r_cwr  <= n_cwr;
        r_rdv  <= n_rdv;
        r_x    <= n_x;
        r_y    <= n_y;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_negq <= n_negq;
        r_negr <= n_negr;
        r_step <= n_step;
        r_out  <= n_out;
    end

    // Slot file: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[r_cmd.dst[SAW-1:0]] <= r_res;
        end
        if (o_pop) begin
            r_rd0_q <= r_slot_mem[i_cmd.rd0[SAW-1:0]];
            r_rd1_q <= r_slot_mem[i_cmd.rd1[SAW-1:0]];
            r_rd0_v <= r_slot_vld[i_cmd.rd0[SAW-1:0]];
            r_rd1_v <= r_slot_vld[i_cmd.rd1[SAW-1:0]];
        end
    end

    // Constant table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (const_we) begin
            r_const_mem[r_cmd.caddr[CAW-1:0]] <= r_res;
        end
        if (o_pop) begin
            r_kq <= r_const_mem[i_cmd.caddr[CAW-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_pop_to_oper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_OPER))
        else $error("command pop did not enter operand stage");

    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && (r_err != rbx_pkg::ERR_NONE)) |-> (!r_wr && !r_cwr))
        else $error("write committed for an erroneous command");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_y != 64'd0))
        else $error("divider running with zero divisor");

    a_pc_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN) |=> (r_pc == $past(r_pc)))
        else $error("program counter changed outside commit");
`endif

endmodule

### hw/rtl/register_bytecode_execute.sv
// ----------------------------------------------------------------------------
// register_bytecode_execute
// Register bytecode execution unit: decode front, command queue and
// execution back with slot file, constant table and program counter.
// ----------------------------------------------------------------------------
// Items are decoded on acceptance and queued (two entries); the execution
// sequencer then handles one command at a time. A write, read, move, add,
// subtract, skip, jump or load passes through read issue, execute and commit
// in the sequencer; a multiply adds a multiply state that builds its 64-bit
// product from three 32x32 partial products on one shared multiplier; a
// divide or modulo adds the bit-serial divider, which yields one quotient
// bit per cycle, and a sign fix. A result waits in the output register while
// further items are still decoded and queued, until the queue is full. The slot
// file reads as zero after reset through per-entry valid bits, so no clearing pass is needed.
module register_bytecode_execute #(
    parameter int unsigned NUM_SLOTS     = 256,
    parameter int unsigned NUM_CONSTANTS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rbx_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rbx_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata
);

    logic [15:0]   r_prog_len;
    logic          push;
    logic          full;
    logic          pop;
    logic          q_valid;
    rbx_pkg::t_cmd f_cmd;
    rbx_pkg::t_cmd q_cmd;

    // Program length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
        end else if (i_cfg_we) begin
            r_prog_len <= i_cfg_wdata;
        end
    end

    rbx_front #(
        .NUM_SLOTS     (NUM_SLOTS),
        .NUM_CONSTANTS (NUM_CONSTANTS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (f_cmd)
    );

    rbx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    rbx_back #(
        .NUM_SLOTS     (NUM_SLOTS),
        .NUM_CONSTANTS (NUM_CONSTANTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_prog_len  (r_prog_len),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### tb/tb_register_bytecode_execute.sv
// ----------------------------------------------------------------------------
// tb_register_bytecode_execute
// Self-checking bench for the register bytecode execution unit: a directed
// table followed by random programs, scored transaction by transaction
// against a behavioral interpreter with its own slots, constants and pc.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_register_bytecode_execute;

    localparam int NSLOT  = 256;
    localparam int NCONST = 256;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    rbx_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    rbx_pkg::t_out o_out_data;
    logic          i_cfg_we;
    logic  [15:0]  i_cfg_wdata;

    register_bytecode_execute #(.NUM_SLOTS(NSLOT), .NUM_CONSTANTS(NCONST)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // Interpreter state
    logic [63:0] slots [NSLOT];
    logic [63:0] consts [NCONST];
    bit          const_known [NCONST];
    logic [15:0] pc;
    logic [15:0] prog_len;

    rbx_pkg::t_out expected_q[$];
    int   errors;
    int   n_sent;
    int   n_recv;
    int   in_idle_pct;
    int   out_idle_pct;
    bit   hold_off;

    // Directed stimulus; chk set where the result is typed in
    typedef struct {
        rbx_pkg::t_in  item;
        bit            chk;
        rbx_pkg::t_out res;
    } t_row;
    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb_register_bytecode_execute: FAIL");
        $finish;
    end

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx8(logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    function automatic logic [63:0] sgn_divmod(logic [63:0] x, logic [63:0] y, bit want_mod);
        logic [63:0] ux;
        logic [63:0] uy;
        logic [63:0] q;
        ux = x[63] ? -x : x;
        uy = y[63] ? -y : y;
        if (want_mod) begin
            q = ux % uy;
            return x[63] ? -q : q;
        end
        q = ux / uy;
        return (x[63] != y[63]) ? -q : q;
    endfunction

    // Run one instruction word on the interpreter state; return error code
    function automatic logic [1:0] run_word(logic [31:0] w);
        logic [7:0]  op;
        logic [7:0]  a;
        logic [7:0]  c;
        logic [7:0]  b;
        logic [15:0] d;
        int          nxt;
        int          tgt;
        int          kind;
        int          grp;
        logic [1:0]  err;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] s;
        op = w[7:0]; a = w[15:8]; c = w[23:16]; b = w[31:24]; d = w[31:16];
        nxt = int'(pc) + 1;
        err = rbx_pkg::ERR_NONE;
        if (op == rbx_pkg::OP_ISEQN || op == rbx_pkg::OP_ISNEN) begin
            if ((slots[a] == sx16(d)) == (op == rbx_pkg::OP_ISEQN)) nxt = int'(pc) + 2;
        end else if (op == rbx_pkg::OP_JMP) begin
            tgt = int'(pc) + 1 + int'($signed(d));
            if (tgt < 0 || tgt > int'(prog_len)) err = rbx_pkg::ERR_RANGE;
            else nxt = tgt;
        end else if (op >= rbx_pkg::OP_MOV && op <= rbx_pkg::OP_ABS) begin
            s = slots[d[7:0]];
            if (d >= NSLOT) err = rbx_pkg::ERR_RANGE;
            else if (op == rbx_pkg::OP_MOV) slots[a] = s;
            else if (op == rbx_pkg::OP_NOT) slots[a] = (s == 64'd0) ? 64'd1 : 64'd0;
            else if (op == rbx_pkg::OP_UNM) slots[a] = -s;
            else slots[a] = s[63] ? -s : s;
        end else if (op >= rbx_pkg::OP_ADDVN && op <= rbx_pkg::OP_MODVV) begin
            kind = (int'(op) - 7) % 5;
            grp  = (int'(op) - 7) / 5;
            if (grp == 0) begin x = slots[b]; y = sx8(c); end
            else if (grp == 1) begin x = sx8(c); y = slots[b]; end
            else begin x = slots[b]; y = slots[c]; end
            if (kind >= 3 && y == 64'd0) err = rbx_pkg::ERR_DIV0;
            else case (kind)
                0: slots[a] = x + y;
                1: slots[a] = x - y;
                2: slots[a] = x * y;
                default: slots[a] = sgn_divmod(x, y, kind == 4);
            endcase
        end else if (op == rbx_pkg::OP_KNUM) begin
            if (d >= NCONST) err = rbx_pkg::ERR_RANGE;
            else slots[a] = consts[d[7:0]];
        end else if (op == rbx_pkg::OP_KLIT) begin
            slots[a] = sx16(d);
        end
        if (err != rbx_pkg::ERR_NONE) nxt = int'(pc) + 1;
        if (nxt > int'(prog_len)) nxt = int'(prog_len);
        pc = nxt[15:0];
        return err;
    endfunction

    function automatic rbx_pkg::t_out predict_step(rbx_pkg::t_in it);
        rbx_pkg::t_out r;
        r = '0;
        case (it.mode)
            rbx_pkg::MODE_WSLOT:  slots[it.index] = it.value;
            rbx_pkg::MODE_WCONST: begin
                consts[it.index] = it.value;
                const_known[it.index] = 1'b1;
            end
            rbx_pkg::MODE_EXEC:   if (pc < prog_len) r.error = run_word(it.instruction);
            default:              r.read_value = slots[it.index];
        endcase
        r.next_pc  = pc;
        r.done_res = (pc >= prog_len);
        return r;
    endfunction

    // Hand one transaction to the block, idling at random before it;
    // valid stays up after acceptance so the next one can follow directly
    task automatic send_item(rbx_pkg::t_in it);
        while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    task automatic send_checked(rbx_pkg::t_in it);
        expected_q.push_back(predict_step(it));
        send_item(it);
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_length(logic [15:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        prog_len = len;
    endtask

    function automatic rbx_pkg::t_in mk(logic [1:0] m, logic [31:0] w, logic [7:0] ix,
                                        logic [63:0] v);
        rbx_pkg::t_in it;
        it.mode = m; it.instruction = w; it.index = ix; it.value = v;
        return it;
    endfunction

    function automatic logic [31:0] word(logic [7:0] op, logic [7:0] a, logic [15:0] d);
        return {d, a, op};
    endfunction

    function automatic rbx_pkg::t_out res(logic [15:0] npc, bit dn, logic [63:0] rv,
                                          logic [1:0] e);
        rbx_pkg::t_out r;
        r.next_pc = npc; r.done_res = dn; r.read_value = rv; r.error = e;
        return r;
    endfunction

    function automatic void add_row(rbx_pkg::t_in it, bit chk = 1'b0,
                                    rbx_pkg::t_out r = '0);
        t_row rw;
        rw.item = it; rw.chk = chk; rw.res = r;
        rows.push_back(rw);
    endfunction

    // Random word, biased toward slots that hold interesting data
    function automatic logic [31:0] rand_word();
        logic [7:0]  op;
        logic [31:0] w;
        w = $urandom;
        op = ($urandom_range(19) == 0) ? 8'($urandom_range(24, 255))
                                       : 8'($urandom_range(0, 23));
        if ($urandom_range(3) != 0) begin
            w[15:8]  = 8'($urandom_range(15));
            w[31:24] = 8'($urandom_range(15));
            if ($urandom_range(2) != 0) w[23:16] = 8'($urandom_range(15));
        end
        if ((op == rbx_pkg::OP_MOV || op == rbx_pkg::OP_NOT || op == rbx_pkg::OP_UNM
             || op == rbx_pkg::OP_ABS) && $urandom_range(7) != 0) w[31:24] = 8'd0;
        if (op == rbx_pkg::OP_KNUM) w[31:16] = ($urandom_range(7) == 0)
                                               ? 16'($urandom) : 16'($urandom_range(15));
        if (op == rbx_pkg::OP_JMP) w[31:16] = 16'($signed($urandom_range(0, 12)) - 6);
        if ((op == rbx_pkg::OP_ISEQN || op == rbx_pkg::OP_ISNEN) && $urandom_range(1))
            w[31:16] = slots[w[15:8]][15:0];
        w[7:0] = op;
        return w;
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(4))
            0: return {$urandom, $urandom};
            1: return 64'h8000_0000_0000_0000;
            2: return 64'h7fff_ffff_ffff_ffff;
            3: return sx8(8'($urandom));
            default: return {$urandom_range(1) ? 32'hffff_ffff : 32'h0, $urandom};
        endcase
    endfunction

    // Score results in arrival order
    always @(posedge i_clk) begin
        rbx_pkg::t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_recv++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_out_data.next_pc !== exp_r.next_pc) begin
                    $display("%0t: next_pc exp %0d got %0d", $time, exp_r.next_pc,
                             o_out_data.next_pc);
                    errors++;
                end
                if (o_out_data.done_res !== exp_r.done_res) begin
                    $display("%0t: done_res exp %0d got %0d", $time, exp_r.done_res,
                             o_out_data.done_res);
                    errors++;
                end
                if (o_out_data.read_value !== exp_r.read_value) begin
                    $display("%0t: read_value exp %h got %h", $time, exp_r.read_value,
                             o_out_data.read_value);
                    errors++;
                end
                if (o_out_data.error !== exp_r.error) begin
                    $display("%0t: error exp %0d got %0d", $time, exp_r.error,
                             o_out_data.error);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when requested
    initial begin
        int cnt;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                for (cnt = 0; cnt < 300; cnt++) @(posedge i_clk);
                hold_off = 0;
            end
            i_out_ready <= !(out_idle_pct > 0 && $urandom_range(99) < out_idle_pct);
        end
    end

    initial begin
        int i;
        int ph;
        rbx_pkg::t_in  it;
        rbx_pkg::t_out pred;
        logic [15:0] len;
        errors = 0; n_sent = 0; n_recv = 0;
        in_idle_pct = 0; out_idle_pct = 0; hold_off = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        foreach (slots[k]) slots[k] = '0;
        foreach (consts[k]) begin consts[k] = '0; const_known[k] = 0; end
        pc = '0; prog_len = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset state, then a selection of opcodes and corners
        add_row(mk(rbx_pkg::MODE_READ, '0, 8'd255, '0), 1'b1,
                res(16'd0, 1'b1, 64'd0, rbx_pkg::ERR_NONE));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_KLIT, 8'd1, 16'h1234), 8'd0, '0),
                1'b1, res(16'd0, 1'b1, 64'd0, rbx_pkg::ERR_NONE));
        add_row(mk(rbx_pkg::MODE_WSLOT, '0, 8'd255, 64'h7fff_ffff_ffff_ffff), 1'b1,
                res(16'd0, 1'b1, 64'd0, rbx_pkg::ERR_NONE));
        add_row(mk(rbx_pkg::MODE_READ, '0, 8'd255, '0), 1'b1,
                res(16'd0, 1'b1, 64'h7fff_ffff_ffff_ffff, rbx_pkg::ERR_NONE));
        add_row(mk(rbx_pkg::MODE_WSLOT, '0, 8'd0, 64'h8000_0000_0000_0000));
        add_row(mk(rbx_pkg::MODE_WCONST, '0, 8'd255, 64'hdead_beef_0123_4567));
        add_row(mk(rbx_pkg::MODE_WCONST, '0, 8'd0, 64'hffff_ffff_ffff_ffff));
        foreach (rows[k]) begin
            pred = predict_step(rows[k].item);
            expected_q.push_back(rows[k].chk ? rows[k].res : pred);
            send_item(rows[k].item);
        end
        rows.delete();
        drain();
        set_length(16'd40);
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_KLIT, 8'd2, 16'hffff), 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_KNUM, 8'd3, 16'd255), 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_KNUM, 8'd3, 16'd256), 8'd0, '0),
                1'b1, res(16'd3, 1'b0, 64'd0, rbx_pkg::ERR_RANGE));
        add_row(mk(rbx_pkg::MODE_EXEC, {8'd0, 8'hff, 8'd4, rbx_pkg::OP_DIVVN}, 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, {8'd0, 8'hff, 8'd5, rbx_pkg::OP_MODVN}, 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, {8'd9, 8'h00, 8'd4, rbx_pkg::OP_DIVVN}, 8'd0, '0),
                1'b1, res(16'd6, 1'b0, 64'd0, rbx_pkg::ERR_DIV0));
        add_row(mk(rbx_pkg::MODE_EXEC, {8'd9, 8'h07, 8'd4, rbx_pkg::OP_MODNV}, 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, {8'd255, 8'd2, 8'd6, rbx_pkg::OP_MULVV}, 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, {8'd0, 8'h80, 8'd7, rbx_pkg::OP_SUBNV}, 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_ABS, 8'd8, 16'd0), 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_UNM, 8'd9, 16'd255), 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_NOT, 8'd10, 16'd11), 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_MOV, 8'd11, 16'd300), 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_ISEQN, 8'd2, 16'hffff), 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_ISNEN, 8'd2, 16'hffff), 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_JMP, 8'd0, 16'h8000), 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, 32'hffff_ff99, 8'd0, '0));
        add_row(mk(rbx_pkg::MODE_EXEC, word(rbx_pkg::OP_JMP, 8'd0, 16'd20), 8'd0, '0));
        foreach (rows[k]) begin
            pred = predict_step(rows[k].item);
            expected_q.push_back(rows[k].chk ? rows[k].res : pred);
            send_item(rows[k].item);
        end
        drain();

        // Random programs over three idling phases and several lengths
        for (ph = 0; ph < 3; ph++) begin
            in_idle_pct  = (ph == 0) ? 19 : (ph == 1) ? 61 : 0;
            out_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 19 : 0;
            if (ph == 2) hold_off = 1;
            for (i = 0; i < 270; i++) begin
                if (i % 45 == 0) begin
                    drain();
                    len = (i == 0 && ph == 0) ? 16'd0 : (i == 45 && ph == 2) ? 16'hffff
                          : 16'($urandom_range(4, 60));
                    set_length(len);
                end
                case ($urandom_range(9))
                    0: it = mk(rbx_pkg::MODE_WSLOT, $urandom,
                               ($urandom_range(4) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(15)),
                               rand_value());
                    1: it = mk(rbx_pkg::MODE_WCONST, $urandom,
                               ($urandom_range(3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(15)),
                               rand_value());
                    2: it = mk(rbx_pkg::MODE_READ, $urandom,
                               ($urandom_range(3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(15)),
                               {$urandom, $urandom});
                    default: it = mk(rbx_pkg::MODE_EXEC, rand_word(), 8'($urandom),
                                     {$urandom, $urandom});
                endcase
                // Keep constant reads within written entries
                if (it.mode == rbx_pkg::MODE_EXEC
                    && it.instruction[7:0] == rbx_pkg::OP_KNUM
                    && it.instruction[31:16] < NCONST
                    && !const_known[it.instruction[23:16]])
                    it.instruction[7:0] = rbx_pkg::OP_KLIT;
                send_checked(it);
            end
        end

        drain();
        $display("Covered %0d transactions in, %0d results out, all opcodes, error codes,",
                 n_sent, n_recv);
        $display("program lengths 0 to 65535 and a long output hold-off.");
        if (errors == 0) begin
            $display("tb_register_bytecode_execute: PASS");
        end else begin
            $display("tb_register_bytecode_execute: FAIL");
        end
        $finish;
    end

endmodule
